// ===== rtl/qoi_pixel_chunk_encoder_macros.svh =====
// ---------------------------------------------------------------------------
// qoi_pixel_chunk_encoder_macros.svh
// Assertion macros shared by the chunk encoder RTL.
// ---------------------------------------------------------------------------
`ifndef QOI_PIXEL_CHUNK_ENCODER_MACROS_SVH
`define QOI_PIXEL_CHUNK_ENCODER_MACROS_SVH

// condition in a cycle implies a property in the same cycle
`define QPCE_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// condition in a cycle implies a property in the next cycle
`define QPCE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/qpce_pkg.sv =====
// ---------------------------------------------------------------------------
// qpce_pkg
// Types and constants of the QOI pixel chunk encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package qpce_pkg;

	// chunk opcodes
	localparam logic [7:0] OP_INDEX = 8'h00;
	localparam logic [7:0] OP_DIFF  = 8'h40;
	localparam logic [7:0] OP_LUMA  = 8'h80;
	localparam logic [7:0] OP_RUN   = 8'hc0;
	localparam logic [7:0] OP_RGB   = 8'hfe;
	localparam logic [7:0] OP_RGBA  = 8'hff;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
	localparam int RUN_MAX   = 62;
	localparam int RUN_W     = 6;

	// default sizes
	localparam int INDEX_ENTRIES_DEF = 64;
	localparam int QUEUE_DEPTH_DEF   = 4;

	// most bytes one pixel can cause: run byte plus an RGBA chunk
	localparam int MAX_BYTES = 6;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int POS_W     = $clog2(MAX_BYTES);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       final_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] chunk_byte;
		logic       last_byte;
	} chunk_out_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pixel_t;

	// work for the back end: the bytes of one pixel, in order
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          nbytes;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

// ===== rtl/qpce_queue.sv =====
// ---------------------------------------------------------------------------
// qpce_queue
// Small FIFO of byte commands between the classifier and the serializer.
// ---------------------------------------------------------------------------
`default_nettype none

module qpce_queue #(
	parameter int DEPTH = qpce_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire qpce_pkg::cmd_t   push_data,
	input  wire logic             pop,
	output qpce_pkg::cmd_t        head,
	output qpce_pkg::q_status_t   status
);
	import qpce_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	cmd_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] cnt_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_QW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_QW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == CNT_QW'(DEPTH));

endmodule

`default_nettype wire

// ===== rtl/qpce_front.sv =====
// ---------------------------------------------------------------------------
// qpce_front
// Accepts pixels, keeps run, previous pixel and color index, and turns each
// pixel into the list of chunk bytes it causes.
// ---------------------------------------------------------------------------
`default_nettype none

module qpce_front #(
	parameter int INDEX_ENTRIES = qpce_pkg::INDEX_ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic                cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire qpce_pkg::pix_in_t   in_data,
	input  wire qpce_pkg::q_status_t q_status,
	output logic                     push,
	output qpce_pkg::cmd_t           push_data
);
	import qpce_pkg::*;

	localparam int IDX_W = $clog2(INDEX_ENTRIES);
	localparam int SUM_W = 13;

	// configuration and state
	logic                     four_channels_q;
	pixel_t                   prev_q;
	logic [RUN_W-1:0]         run_q;
	logic [INDEX_ENTRIES-1:0] idx_vld_q;
	pixel_t                   idx_mem [INDEX_ENTRIES];

	// stage 1: accepted pixel with its index lookup
	logic                     valid_s1;
	pixel_t                   px_s1;
	logic                     fin_s1;
	logic [IDX_W-1:0]         hash_s1;
	pixel_t                   rd_s1;
	logic                     byp_hit_s1;
	pixel_t                   byp_data_s1;

	logic                     accept;
	logic                     adv;
	pixel_t                   px_in;
	logic [SUM_W-1:0]         sum_in;
	logic [IDX_W-1:0]         hash_in;

	pixel_t                   entry;
	logic                     same;
	logic                     hit;
	logic                     wr_en;
	logic [RUN_W-1:0]         run_d;
	logic                     rf;
	logic [7:0]               run_b;
	logic [MAX_BYTES-1:0][7:0] c;
	logic [CNT_W-1:0]         cn;
	logic [MAX_BYTES-1:0][7:0] bl;
	logic [CNT_W-1:0]         n;
	logic signed [7:0]        dr;
	logic signed [7:0]        dg;
	logic signed [7:0]        db;
	logic signed [8:0]        drg;
	logic signed [8:0]        dbg;
	logic [7:0]               dr2;
	logic [7:0]               dg2;
	logic [7:0]               db2;
	logic [7:0]               dg32;
	logic [8:0]               drg8;
	logic [8:0]               dbg8;

	// handshake: stage 1 moves on when the queue has room
	assign adv      = valid_s1 && !q_status.full;
	assign in_stall = valid_s1 && q_status.full;
	assign accept   = in_valid && !in_stall;

	// incoming pixel, alpha forced opaque in three-channel mode
	always_comb begin
		px_in.r = in_data.red;
		px_in.g = in_data.green;
		px_in.b = in_data.blue;
		px_in.a = four_channels_q ? in_data.alpha : ALPHA_OPAQUE;
		sum_in  = SUM_W'(px_in.r) * SUM_W'(3) + SUM_W'(px_in.g) * SUM_W'(5)
			+ SUM_W'(px_in.b) * SUM_W'(7) + SUM_W'(px_in.a) * SUM_W'(11);
		hash_in = sum_in[IDX_W-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_channels_q <= 1'b1;
			valid_s1        <= 1'b0;
			prev_q          <= '{r: 8'h00, g: 8'h00, b: 8'h00, a: ALPHA_OPAQUE};
			run_q           <= '0;
			idx_vld_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				four_channels_q <= cfg_wr_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				prev_q <= px_s1;
				run_q  <= run_d;
			end
			if (wr_en) begin
				idx_vld_q[hash_s1] <= 1'b1;
			end
		end
	end

	// stage 1 payload and index read; bypass a write landing on the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1       <= px_in;
			fin_s1      <= in_data.final_pixel;
			hash_s1     <= hash_in;
			rd_s1       <= idx_mem[hash_in];
			byp_hit_s1  <= wr_en && (hash_s1 == hash_in);
			byp_data_s1 <= px_s1;
		end
	end

	// index write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			idx_mem[hash_s1] <= px_s1;
		end
	end

	// channel differences
	always_comb begin
		dr   = px_s1.r - prev_q.r;
		dg   = px_s1.g - prev_q.g;
		db   = px_s1.b - prev_q.b;
		drg  = {dr[7], dr} - {dg[7], dg};
		dbg  = {db[7], db} - {dg[7], dg};
		dr2  = dr + 8'sd2;
		dg2  = dg + 8'sd2;
		db2  = db + 8'sd2;
		dg32 = dg + 8'sd32;
		drg8 = drg + 9'sd8;
		dbg8 = dbg + 9'sd8;
	end

	// classification
	always_comb begin
		entry = byp_hit_s1 ? byp_data_s1 : (idx_vld_q[hash_s1] ? rd_s1 : '0);
		same  = (px_s1 == prev_q);
		hit   = (entry == px_s1);
		wr_en = 1'b0;
		run_d = run_q;
		rf    = 1'b0;
		run_b = '0;
		c     = '0;
		cn    = '0;
		if (same) begin
			// run grows; flush at its limit or at the image end
			if (run_q >= RUN_W'(RUN_MAX - 1) || fin_s1) begin
				rf    = 1'b1;
				run_b = OP_RUN | {2'b00, run_q};
				run_d = '0;
			end else begin
				run_d = run_q + RUN_W'(1);
			end
		end else begin
			run_d = '0;
			if (run_q != '0) begin
				rf    = 1'b1;
				run_b = OP_RUN | {2'b00, run_q - RUN_W'(1)};
			end
			priority if (hit) begin
				c[0] = OP_INDEX | 8'(hash_s1);
				cn   = CNT_W'(1);
			end else begin
				wr_en = adv;
				priority if (px_s1.a != prev_q.a) begin
					c[0] = OP_RGBA;
					c[1] = px_s1.r;
					c[2] = px_s1.g;
					c[3] = px_s1.b;
					c[4] = px_s1.a;
					cn   = CNT_W'(5);
				end else if (dr >= -8'sd2 && dr <= 8'sd1 && dg >= -8'sd2 && dg <= 8'sd1
						&& db >= -8'sd2 && db <= 8'sd1) begin
					c[0] = OP_DIFF | {2'b00, dr2[1:0], dg2[1:0], db2[1:0]};
					cn   = CNT_W'(1);
				end else if (dg >= -8'sd32 && dg <= 8'sd31 && drg >= -9'sd8 && drg <= 9'sd7
						&& dbg >= -9'sd8 && dbg <= 9'sd7) begin
					c[0] = OP_LUMA | {2'b00, dg32[5:0]};
					c[1] = {drg8[3:0], dbg8[3:0]};
					cn   = CNT_W'(2);
				end else begin
					c[0] = OP_RGB;
					c[1] = px_s1.r;
					c[2] = px_s1.g;
					c[3] = px_s1.b;
					cn   = CNT_W'(4);
				end
			end
		end
	end

	// byte list: optional run byte ahead of the chunk
	always_comb begin
		bl = rf ? {c[MAX_BYTES-2:0], run_b} : c;
		n  = cn + CNT_W'(rf);
	end

	assign push             = adv && (n != '0);
	assign push_data.bytes  = bl;
	assign push_data.nbytes = n;

endmodule

`default_nettype wire

// ===== rtl/qpce_back.sv =====
// ---------------------------------------------------------------------------
// qpce_back
// Serializes queued byte lists into the output register, one byte a cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module qpce_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire qpce_pkg::cmd_t      head,
	input  wire qpce_pkg::q_status_t q_status,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output qpce_pkg::chunk_out_t     out_data
);
	import qpce_pkg::*;

	logic             out_valid_q;
	chunk_out_t       out_data_q;
	logic [POS_W-1:0] pos_q;
	logic             load;
	logic             take;
	logic             last;

	// output register frees up when empty or taken
	assign load = !out_valid_q || !out_stall;
	assign take = load && !q_status.empty;
	assign last = (CNT_W'(pos_q) + CNT_W'(1)) == head.nbytes;
	assign pop  = take && last;

	// byte position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= !q_status.empty;
			end
			if (take) begin
				pos_q <= last ? '0 : pos_q + POS_W'(1);
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q.chunk_byte <= head.bytes[pos_q];
			out_data_q.last_byte  <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/qoi_pixel_chunk_encoder.sv =====
// ---------------------------------------------------------------------------
// qoi_pixel_chunk_encoder
// QOI chunk stream encoder: one RGBA pixel in, its chunk bytes out.
//
//   channel   direction  handshake              payload
//   pixel     in         in_valid / in_stall    pix_in_t (red..final_pixel)
//   chunk     out        out_valid / out_stall  chunk_out_t (byte, last)
//   config    in         cfg_wr_en              cfg_wr_data (four_channels)
//
// A pixel is taken every cycle while the byte queue has room; a pixel is
// classified in the stage 1 register and lands in the queue when it has room.
// The serializer sends one byte per cycle while out_stall is low; a pixel
// has 0 to 6 bytes, and long chunks stall the input by queue fill.
// A pixel passes the stage 1 register, the queue and the output register.
// Reset clears the color index through per-entry valid bits at once; there is
// no clearing pass. Either side may stall at any time.
// ---------------------------------------------------------------------------
`default_nettype none

`include "qoi_pixel_chunk_encoder_macros.svh"

module qoi_pixel_chunk_encoder #(
	parameter int INDEX_ENTRIES = qpce_pkg::INDEX_ENTRIES_DEF,
	parameter int QUEUE_DEPTH   = qpce_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire qpce_pkg::pix_in_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output qpce_pkg::chunk_out_t   out_data
);
	import qpce_pkg::*;

	logic      push;
	cmd_t      push_data;
	logic      pop;
	cmd_t      head;
	q_status_t q_status;

	// front: accept and classify
	qpce_front #(
		.INDEX_ENTRIES (INDEX_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.q_status    (q_status),
		.push        (push),
		.push_data   (push_data)
	);

	// queue between front and back
	qpce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// back: byte serializer
	qpce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// checks
	`QPCE_ASSERT_SAME(a_no_push_full, clk, arst_n, q_status.full, !push, "push into full queue")
	`QPCE_ASSERT_SAME(a_no_pop_empty, clk, arst_n, pop, !q_status.empty, "pop from empty queue")
	`QPCE_ASSERT_SAME(a_stall_full, clk, arst_n, in_stall, q_status.full, "input stalled with queue room")
	`QPCE_ASSERT_NEXT(a_pop_shows, clk, arst_n, pop, out_valid && out_data.last_byte, "popped item without last byte")

endmodule

`default_nettype wire
